// File: rtl/triangle_point_sampler_assert.svh
// Assertion macros used by the triangle point sampler top level.
`ifndef TRIANGLE_POINT_SAMPLER_ASSERT_SVH
`define TRIANGLE_POINT_SAMPLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tps_pkg.sv
// Package with shared constants and register codes of the triangle point sampler.
`timescale 1ns / 1ps
package tps_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int LEN_FRAC       = 8;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_MODE = 3'd0,
        REG_V1_X      = 3'd1,
        REG_V1_Y      = 3'd2,
        REG_V2_X      = 3'd3,
        REG_V2_Y      = 3'd4,
        REG_V3_X      = 3'd5,
        REG_V3_Y      = 3'd6
    } cfg_reg_t;
endpackage

// File: rtl/tps_side_len.sv
// Side length unit: squares a vertex difference and takes an iterative square root.
`timescale 1ns / 1ps
module tps_side_len #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      start,
    input  logic signed [COORD_BITS:0]                dx,
    input  logic signed [COORD_BITS:0]                dy,
    output logic [COORD_BITS+tps_pkg::LEN_FRAC:0]     len,
    output logic                                      busy
);
    import tps_pkg::*;

    localparam int RAD_W  = 2*COORD_BITS + 2*LEN_FRAC + 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]        rad_reg, rad_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [COORD_BITS:0] ax, ay;
    logic [COORD_BITS-1:0]   mx, my;
    logic [2*COORD_BITS:0]   sq;
    logic [REM_W-1:0]        rem_sh, trial;

    always_comb begin
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        mx = ax[COORD_BITS-1:0];
        my = ay[COORD_BITS-1:0];
        sq = (2*COORD_BITS+1)'(mx * mx) + (2*COORD_BITS+1)'(my * my);
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            rad_next  = {1'b0, sq, {(2*LEN_FRAC){1'b0}}};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
        end else if (cnt_reg != '0) begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            root_reg <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            root_reg <= root_next;
        end
        rad_reg <= rad_next;
        rem_reg <= rem_next;
    end

    assign len  = root_reg;
    assign busy = (cnt_reg != '0);
endmodule

// File: rtl/tps_pipe.sv
// Three-stage sampling datapath: select and fold, multiply, scale and sum.
`timescale 1ns / 1ps
module tps_pipe #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tps_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [FRAC_BITS-1:0]                  r1,
    input  logic [FRAC_BITS-1:0]                  r2,
    input  logic [FRAC_BITS-1:0]                  r3,
    input  logic                                  edge_mode,
    input  logic signed [COORD_BITS-1:0]          x1,
    input  logic signed [COORD_BITS-1:0]          y1,
    input  logic signed [COORD_BITS-1:0]          x2,
    input  logic signed [COORD_BITS-1:0]          y2,
    input  logic signed [COORD_BITS-1:0]          x3,
    input  logic signed [COORD_BITS-1:0]          y3,
    input  logic [COORD_BITS+tps_pkg::LEN_FRAC:0] l1,
    input  logic [COORD_BITS+tps_pkg::LEN_FRAC:0] l2,
    input  logic [COORD_BITS+tps_pkg::LEN_FRAC:0] l3,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [COORD_BITS-1:0]                 px,
    output logic [COORD_BITS-1:0]                 py
);
    import tps_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int LEN_W = C + LEN_FRAC + 1;
    localparam int TOT_W = LEN_W + 2;
    localparam int SEL_W = F + TOT_W;
    localparam int P_W   = F + 1 + C;

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    logic signed [C:0] d21x, d21y, d32x, d32y, d13x, d13y, d31x, d31y;
    logic [F:0]        s_f, t_f, sum_st, one;
    logic [TOT_W-1:0]  total;
    logic [SEL_W-1:0]  sel, lim1, lim2;
    logic [F:0]        u1_next, u2_next;
    logic signed [C-1:0] sx_next, sy_next;
    logic signed [C:0] dax_next, day_next, dbx_next, dby_next;

    logic [F:0]          u1_reg, u2_reg;
    logic signed [C-1:0] sx_reg, sy_reg;
    logic signed [C:0]   dax_reg, day_reg, dbx_reg, dby_reg;

    logic signed [C:0]   ad_ax, ad_ay, ad_bx, ad_by;
    logic [P_W-1:0]      pax_reg, pay_reg, pbx_reg, pby_reg;
    logic                nax_reg, nay_reg, nbx_reg, nby_reg;
    logic signed [C-1:0] sx2_reg, sy2_reg;

    logic signed [C+2:0] tax, tay, tbx, tby, sumx, sumy;
    logic [C-1:0]        px_reg, py_reg;

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        d21x = (C+1)'(x2) - (C+1)'(x1);
        d21y = (C+1)'(y2) - (C+1)'(y1);
        d32x = (C+1)'(x3) - (C+1)'(x2);
        d32y = (C+1)'(y3) - (C+1)'(y2);
        d13x = (C+1)'(x1) - (C+1)'(x3);
        d13y = (C+1)'(y1) - (C+1)'(y3);
        d31x = (C+1)'(x3) - (C+1)'(x1);
        d31y = (C+1)'(y3) - (C+1)'(y1);
        one    = {1'b1, {F{1'b0}}};
        sum_st = (F+1)'(r1) + (F+1)'(r2);
        total  = TOT_W'(l1) + TOT_W'(l2) + TOT_W'(l3);
        sel    = SEL_W'(r1) * SEL_W'(total);
        lim1   = SEL_W'({l1, {F{1'b0}}});
        lim2   = SEL_W'({(LEN_W+1)'(l1) + (LEN_W+1)'(l2), {F{1'b0}}});
        if (sum_st > one) begin
            s_f = one - (F+1)'(r1);
            t_f = one - (F+1)'(r2);
        end else begin
            s_f = (F+1)'(r1);
            t_f = (F+1)'(r2);
        end
        dbx_next = '0;
        dby_next = '0;
        if (edge_mode) begin
            u1_next = (F+1)'(r3);
            u2_next = '0;
            priority if (sel < lim1) begin
                sx_next = x1; sy_next = y1; dax_next = d21x; day_next = d21y;
            end else if (sel < lim2) begin
                sx_next = x2; sy_next = y2; dax_next = d32x; day_next = d32y;
            end else begin
                sx_next = x3; sy_next = y3; dax_next = d13x; day_next = d13y;
            end
        end else begin
            u1_next  = s_f;
            u2_next  = t_f;
            sx_next  = x1;
            sy_next  = y1;
            dax_next = d21x;
            day_next = d21y;
            dbx_next = d31x;
            dby_next = d31y;
        end
    end

    always_comb begin
        ad_ax = (dax_reg < 0) ? -dax_reg : dax_reg;
        ad_ay = (day_reg < 0) ? -day_reg : day_reg;
        ad_bx = (dbx_reg < 0) ? -dbx_reg : dbx_reg;
        ad_by = (dby_reg < 0) ? -dby_reg : dby_reg;
    end

    always_comb begin
        tax = $signed({2'b00, pax_reg[P_W-1:F]});
        tay = $signed({2'b00, pay_reg[P_W-1:F]});
        tbx = $signed({2'b00, pbx_reg[P_W-1:F]});
        tby = $signed({2'b00, pby_reg[P_W-1:F]});
        if (nax_reg) tax = -tax;
        if (nay_reg) tay = -tay;
        if (nbx_reg) tbx = -tbx;
        if (nby_reg) tby = -tby;
        sumx = (C+3)'(sx2_reg) + tax + tbx;
        sumy = (C+3)'(sy2_reg) + tay + tby;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
        if (en1) begin
            u1_reg  <= u1_next;
            u2_reg  <= u2_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            dax_reg <= dax_next;
            day_reg <= day_next;
            dbx_reg <= dbx_next;
            dby_reg <= dby_next;
        end
        if (en2) begin
            pax_reg <= P_W'(u1_reg) * P_W'(ad_ax[C-1:0]);
            pay_reg <= P_W'(u1_reg) * P_W'(ad_ay[C-1:0]);
            pbx_reg <= P_W'(u2_reg) * P_W'(ad_bx[C-1:0]);
            pby_reg <= P_W'(u2_reg) * P_W'(ad_by[C-1:0]);
            nax_reg <= dax_reg[C];
            nay_reg <= day_reg[C];
            nbx_reg <= dbx_reg[C];
            nby_reg <= dby_reg[C];
            sx2_reg <= sx_reg;
            sy2_reg <= sy_reg;
        end
        if (en3) begin
            px_reg <= sumx[C-1:0];
            py_reg <= sumy[C-1:0];
        end
    end

    assign out_valid = v3_reg;
    assign px = px_reg;
    assign py = py_reg;
endmodule

// File: rtl/triangle_point_sampler.sv
// Top level of the triangle point sampler: configuration, side lengths and datapath.
//
//  Channel   Direction  Payload
//  s_axis    in         rand_first, rand_second, rand_third
//  m_axis    out        point_x, point_y
//  cfg       in         register index and write data
//
// One item per cycle enters the three-stage datapath while s_tready is high.
// Reset is synchronous and active low; all vertices and the mode clear to zero.
// After any register write, three iterative square root units recompute the side
// lengths in COORD_BITS+9 steps; s_tready stays low until all three are done.
// Stages advance independently, so bubbles fill while m_tready is low.
`timescale 1ns / 1ps
module triangle_point_sampler #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tps_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // rand_first, rand_second, rand_third
    input  logic [((3*FRAC_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // point_x, point_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
    input  logic                                  cfg_we,
    input  logic [tps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [COORD_BITS-1:0]                 cfg_wdata
);
    import tps_pkg::*;

    localparam int LEN_W = COORD_BITS + LEN_FRAC + 1;
    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

    logic                         edge_mode_reg;
    logic signed [COORD_BITS-1:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic                         start_reg;
    logic                         lens_valid_reg, lens_valid_next;
    logic [LEN_W-1:0]             l1, l2, l3;
    logic                         b1, b2, b3;
    logic                         pipe_ready;
    logic [COORD_BITS-1:0]        px, py;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_mode_reg <= 1'b0;
            x1_reg <= '0; y1_reg <= '0;
            x2_reg <= '0; y2_reg <= '0;
            x3_reg <= '0; y3_reg <= '0;
            start_reg      <= 1'b0;
            lens_valid_reg <= 1'b1;
        end else begin
            start_reg      <= cfg_we;
            lens_valid_reg <= lens_valid_next;
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_EDGE_MODE: edge_mode_reg <= cfg_wdata[0];
                    REG_V1_X:      x1_reg <= cfg_wdata;
                    REG_V1_Y:      y1_reg <= cfg_wdata;
                    REG_V2_X:      x2_reg <= cfg_wdata;
                    REG_V2_Y:      y2_reg <= cfg_wdata;
                    REG_V3_X:      x3_reg <= cfg_wdata;
                    REG_V3_Y:      y3_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        if (cfg_we || start_reg) begin
            lens_valid_next = 1'b0;
        end else if (!b1 && !b2 && !b3) begin
            lens_valid_next = 1'b1;
        end else begin
            lens_valid_next = lens_valid_reg;
        end
    end

    tps_side_len #(.COORD_BITS(COORD_BITS)) u_len1 (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg),
        .dx((COORD_BITS+1)'(x2_reg) - (COORD_BITS+1)'(x1_reg)),
        .dy((COORD_BITS+1)'(y2_reg) - (COORD_BITS+1)'(y1_reg)),
        .len(l1), .busy(b1)
    );

    tps_side_len #(.COORD_BITS(COORD_BITS)) u_len2 (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg),
        .dx((COORD_BITS+1)'(x3_reg) - (COORD_BITS+1)'(x2_reg)),
        .dy((COORD_BITS+1)'(y3_reg) - (COORD_BITS+1)'(y2_reg)),
        .len(l2), .busy(b2)
    );

    tps_side_len #(.COORD_BITS(COORD_BITS)) u_len3 (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg),
        .dx((COORD_BITS+1)'(x1_reg) - (COORD_BITS+1)'(x3_reg)),
        .dy((COORD_BITS+1)'(y1_reg) - (COORD_BITS+1)'(y3_reg)),
        .len(l3), .busy(b3)
    );

    assign s_tready = pipe_ready && lens_valid_reg;

    tps_pipe #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_pipe (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid && lens_valid_reg), .in_ready(pipe_ready),
        .r1(s_tdata[FRAC_BITS-1:0]),
        .r2(s_tdata[2*FRAC_BITS-1:FRAC_BITS]),
        .r3(s_tdata[3*FRAC_BITS-1:2*FRAC_BITS]),
        .edge_mode(edge_mode_reg),
        .x1(x1_reg), .y1(y1_reg), .x2(x2_reg), .y2(y2_reg), .x3(x3_reg), .y3(y3_reg),
        .l1(l1), .l2(l2), .l3(l3),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .px(px), .py(py)
    );

    assign m_tdata = OUT_W'({py, px});

    `include "triangle_point_sampler_assert.svh"

    `TPS_ASSERT_SAME(a_ready_lens, s_tready, lens_valid_reg && !b1 && !b2 && !b3, "stale lengths")
    `TPS_ASSERT_NEXT(a_write_blocks_input, cfg_we, !s_tready, "input open after write")
    `TPS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
endmodule

// File: dv/tb_triangle_point_sampler.sv
// Self-checking testbench of the triangle point sampler: directed table, then random items.
`timescale 1ns / 1ps
module tb_triangle_point_sampler;
    import tps_pkg::*;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] x;
    } point_t;

    typedef struct {
        logic [FB-1:0] r1;
        logic [FB-1:0] r2;
        logic [FB-1:0] r3;
        bit            known;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
    } row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [31:0] m_tdata;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CB-1:0] cfg_wdata = '0;

    logic edge_sel;
    logic signed [CB-1:0] vx1, vy1, vx2, vy2, vx3, vy3;
    point_t expected_points[$];
    row_t rows[$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 0;

    triangle_point_sampler i_dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Truncating product of a Q0.16 fraction and a signed difference.
    function automatic longint frac_scale(logic [FB-1:0] u, longint d);
        longint q;
        q = (longint'(u) * (d < 0 ? -d : d)) >>> FB;
        return d < 0 ? -q : q;
    endfunction

    function automatic longint side_length(longint dx, longint dy);
        longint sq, r, c;
        sq = (dx * dx + dy * dy) << 16;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (longint'(1) << b);
            if (c * c <= sq) r = c;
        end
        return r;
    endfunction

    function automatic point_t sample_point(logic [FB-1:0] r1, r2, r3);
        longint x1, y1, x2, y2, x3, y3, l1, l2, l3, px, py, s, t;
        logic [127:0] sel;
        point_t p;
        x1 = vx1; y1 = vy1; x2 = vx2; y2 = vy2; x3 = vx3; y3 = vy3;
        if (edge_sel) begin
            l1 = side_length(x2 - x1, y2 - y1);
            l2 = side_length(x3 - x2, y3 - y2);
            l3 = side_length(x1 - x3, y1 - y3);
            sel = 128'(r1) * 128'(l1 + l2 + l3);
            if (sel < (128'(l1) << FB)) begin
                px = x1 + frac_scale(r3, x2 - x1);
                py = y1 + frac_scale(r3, y2 - y1);
            end else if (sel < (128'(l1 + l2) << FB)) begin
                px = x2 + frac_scale(r3, x3 - x2);
                py = y2 + frac_scale(r3, y3 - y2);
            end else begin
                px = x3 + frac_scale(r3, x1 - x3);
                py = y3 + frac_scale(r3, y1 - y3);
            end
        end else begin
            s = r1;
            t = r2;
            if (s + t > 65536) begin
                s = 65536 - s;
                t = 65536 - t;
            end
            px = x1 + frac_scale(FB'(s), x2 - x1) + frac_scale(FB'(t), x3 - x1);
            py = y1 + frac_scale(FB'(s), y2 - y1) + frac_scale(FB'(t), y3 - y1);
            if (s == 65536) px = x1 + (x2 - x1) + frac_scale(FB'(t), x3 - x1);
            if (s == 65536) py = y1 + (y2 - y1) + frac_scale(FB'(t), y3 - y1);
            if (t == 65536) px = x1 + frac_scale(FB'(s), x2 - x1) + (x3 - x1);
            if (t == 65536) py = y1 + frac_scale(FB'(s), y2 - y1) + (y3 - y1);
        end
        p.x = px[CB-1:0];
        p.y = py[CB-1:0];
        return p;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CB-1:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_EDGE_MODE: edge_sel = val[0];
            REG_V1_X: vx1 = val;
            REG_V1_Y: vy1 = val;
            REG_V2_X: vx2 = val;
            REG_V2_Y: vy2 = val;
            REG_V3_X: vx3 = val;
            REG_V3_Y: vy3 = val;
            default: ;
        endcase
    endtask

    task automatic set_triangle(logic mode, logic [CB-1:0] a, b, c, d, e, f);
        s_tvalid <= 0;
        wait (expected_points.size() == 0);
        repeat (8) @(posedge aclk);
        write_reg(REG_EDGE_MODE, CB'(mode));
        write_reg(REG_V1_X, a);
        write_reg(REG_V1_Y, b);
        write_reg(REG_V2_X, c);
        write_reg(REG_V2_Y, d);
        write_reg(REG_V3_X, e);
        write_reg(REG_V3_Y, f);
        cfg_we <= 0;
    endtask

    task automatic send_item(logic [FB-1:0] r1, r2, r3, point_t want);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {r3, r2, r1};
        expected_points = {expected_points, want};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_row(row_t r);
        point_t want;
        if (r.known) begin
            want.x = r.ex;
            want.y = r.ey;
        end else begin
            want = sample_point(r.r1, r.r2, r.r3);
        end
        send_item(r.r1, r.r2, r.r3, want);
    endtask

    task automatic add_row(logic [FB-1:0] r1, r2, r3, bit known, logic [CB-1:0] ex, ey);
        row_t r;
        r.r1 = r1;
        r.r2 = r2;
        r.r3 = r3;
        r.known = known;
        r.ex = ex;
        r.ey = ey;
        rows = {rows, r};
    endtask

    always @(posedge aclk) begin
        if (hold_off) m_tready <= 0;
        else m_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge aclk) begin
        point_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_points.size() == 0) begin
                $error("result with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want = expected_points.pop_front();
                if (got.x !== want.x) begin
                    $error("point_x expected %0d got %0d", want.x, got.x);
                    errors++;
                end
                if (got.y !== want.y) begin
                    $error("point_y expected %0d got %0d", want.y, got.y);
                    errors++;
                end
            end
        end
    end

    task automatic random_triangle();
        logic [CB-1:0] v[6];
        for (int i = 0; i < 6; i++) begin
            case ($urandom_range(3))
                0: v[i] = $urandom_range(3) == 0 ? 16'h8000 : 16'h7fff;
                1: v[i] = CB'($urandom_range(64) - 32);
                default: v[i] = CB'($urandom);
            endcase
        end
        set_triangle(1'($urandom_range(1)), v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    initial begin
        edge_sel = 0;
        {vx1, vy1, vx2, vy2, vx3, vy3} = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // After reset every vertex is the origin.
        add_row(16'hffff, 16'hffff, 16'hffff, 1'b1, 16'h0, 16'h0);
        add_row(16'h0, 16'h0, 16'h0, 1'b1, 16'h0, 16'h0);
        foreach (rows[i]) send_row(rows[i]);
        rows.delete();

        // Surface on extreme triangle, including the fold boundary s + t = 1.
        set_triangle(0, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        add_row(16'h0, 16'h0, 16'h1234, 1'b1, 16'h8000, 16'h8000);
        add_row(16'h8000, 16'h8000, 16'h0, 1'b0, 16'h0, 16'h0);
        add_row(16'hffff, 16'hffff, 16'hffff, 1'b0, 16'h0, 16'h0);
        add_row(16'hffff, 16'h0001, 16'h0, 1'b0, 16'h0, 16'h0);
        add_row(16'h4000, 16'hc001, 16'h0, 1'b0, 16'h0, 16'h0);
        add_row(16'h5555, 16'haaaa, 16'haaaa, 1'b0, 16'h0, 16'h0);
        foreach (rows[i]) send_row(rows[i]);
        rows.delete();

        // Perimeter sampling, then a degenerate triangle that falls to the third side.
        set_triangle(1, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h0, 16'h8000);
        add_row(16'h0, 16'h0, 16'h0, 1'b1, 16'h7fff, 16'h7fff);
        add_row(16'hffff, 16'hffff, 16'hffff, 1'b0, 16'h0, 16'h0);
        add_row(16'h5555, 16'h0, 16'h8000, 1'b0, 16'h0, 16'h0);
        add_row(16'haaaa, 16'h1, 16'h7fff, 1'b0, 16'h0, 16'h0);
        foreach (rows[i]) send_row(rows[i]);
        rows.delete();
        set_triangle(1, 16'h5, 16'hfffb, 16'h5, 16'hfffb, 16'h5, 16'hfffb);
        add_row(16'h0, 16'h0, 16'hffff, 1'b1, 16'h5, 16'hfffb);
        add_row(16'hffff, 16'hffff, 16'h0, 1'b1, 16'h5, 16'hfffb);
        foreach (rows[i]) send_row(rows[i]);
        rows.delete();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 47; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 47; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            random_triangle();
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (60) @(posedge aclk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 88; n++) begin
                add_row(FB'($urandom), FB'($urandom), FB'($urandom), 1'b0, 16'h0, 16'h0);
                send_row(rows[0]);
                rows.delete();
                if (n == 40) begin
                    s_tvalid <= 0;
                    wait (expected_points.size() == 0);
                end
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        s_tvalid <= 0;
        wait (expected_points.size() == 0);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
